// ===== rtl/phwf_pkg.sv =====
`default_nettype none
package phwf_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int PAGE_SHIFT   = 12;

    localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int BASE_W  = 20;
    localparam int PAGES_W = 21;
    localparam int REQ_W   = 33 - PAGE_SHIFT;
    localparam int CMP_W   = REQ_W + PAGES_W;

    localparam logic [7:0] REG_ALLOC_START = 8'd0;
    localparam logic [7:0] REG_ALLOC_LIMIT = 8'd1;
    localparam logic [7:0] REG_SMALL_START = 8'd2;
    localparam logic [7:0] REG_SMALL_END   = 8'd3;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ZERO_SIZE    = 3'd1,
        ST_NO_ROOM      = 3'd2,
        ST_TABLE_FULL   = 3'd3,
        ST_NOT_FOUND    = 3'd4,
        ST_ALREADY_FREE = 3'd5,
        ST_SMALL_REGION = 3'd6
    } t_status;

    typedef struct packed {
        logic        action;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] base_address;
        logic [31:0] length_bytes;
    } t_out_item;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic               is_free;
    } t_seg;

    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_ROT      = 3'd1,
        CELL_WRITE    = 3'd2,
        CELL_INSERT   = 3'd3,
        CELL_COLLAPSE = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        logic [1:0]       span;
        t_seg             ent_a;
        t_seg             ent_b;
    } t_cell_ctl;

    function automatic logic [31:0] to_bytes(input logic [31:0] pages);
        logic [63:0] wide;
        wide = {32'd0, pages} << PAGE_SHIFT;
        return wide[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/phwf_cell.sv =====
`default_nettype none
module phwf_cell (
    input  wire logic                       i_clk,
    input  wire phwf_pkg::t_cell_ctl        i_ctl,
    input  wire logic [phwf_pkg::IDX_W-1:0] i_idx,
    input  wire phwf_pkg::t_seg             i_left,
    input  wire phwf_pkg::t_seg             i_right1,
    input  wire phwf_pkg::t_seg             i_right2,
    output phwf_pkg::t_seg                  o_seg
);
    import phwf_pkg::*;

    t_seg r_seg;
    t_seg n_seg;
    logic [CNT_W-1:0] pos_next;

    assign pos_next = {1'b0, i_ctl.pos} + CNT_W'(1);

    always_comb begin
        n_seg = r_seg;
        case (i_ctl.op)
            CELL_ROT: begin
                n_seg = i_right1;
            end
            CELL_WRITE: begin
                if (i_idx == i_ctl.pos) n_seg = i_ctl.ent_a;
            end
            CELL_INSERT: begin
                if (i_idx == i_ctl.pos) begin
                    n_seg = i_ctl.ent_a;
                end else if ({1'b0, i_idx} == pos_next) begin
                    n_seg = i_ctl.ent_b;
                end else if (i_idx > i_ctl.pos) begin
                    n_seg = i_left;
                end
            end
            CELL_COLLAPSE: begin
                if (i_idx == i_ctl.pos) begin
                    n_seg = i_ctl.ent_a;
                end else if (i_idx > i_ctl.pos) begin
                    if (i_ctl.span == 2'd1) n_seg = i_right1;
                    else if (i_ctl.span == 2'd2) n_seg = i_right2;
                end
            end
            default: begin
                n_seg = r_seg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign o_seg = r_seg;
endmodule
`default_nettype wire

// ===== rtl/phwf_chain.sv =====
`default_nettype none
module phwf_chain (
    input  wire logic                i_clk,
    input  wire phwf_pkg::t_cell_ctl i_ctl,
    output phwf_pkg::t_seg           o_head
);
    import phwf_pkg::*;

    t_seg w_seg [MAX_SEGMENTS];

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        phwf_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (i_ctl),
            .i_idx    (IDX_W'(g)),
            .i_left   (w_seg[(g + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
            .i_right1 (w_seg[(g + 1) % MAX_SEGMENTS]),
            .i_right2 (w_seg[(g + 2) % MAX_SEGMENTS]),
            .o_seg    (w_seg[g])
        );
    end

    assign o_head = w_seg[0];
endmodule
`default_nettype wire

// ===== rtl/page_heap_worst_fit_allocator.sv =====
`default_nettype none
// Page heap allocator (worst fit, with an exact-size free segment preferred;
// coalescing). Segments live in address order in a chain of cells. A zero-size
// allocate or a free inside the small-block region answers in the cycle after
// start; any other item is searched by one full rotation of the chain past its
// head cell, then makes its update in an apply state. Each item gives one
// result, strobed for one cycle; the receiver must take it then. Configuration
// writes are taken only while idle and no item is being started.
module page_heap_worst_fit_allocator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire phwf_pkg::t_in_item  i_item,
    output phwf_pkg::t_out_item      o_result,
    output logic                     o_result_strobe,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);
    import phwf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PAGES_W-1:0] r_break, n_break;
    logic [BASE_W-1:0]  r_start_pg, n_start_pg;
    logic [PAGES_W-1:0] r_limit_pg, n_limit_pg;
    logic [31:0]        r_small_lo, n_small_lo;
    logic [31:0]        r_small_hi, n_small_hi;
    logic               r_action, n_action;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [31:0]        r_addr, n_addr;
    logic [CNT_W-1:0]   r_k, n_k;
    t_seg               r_last, n_last;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_p, n_p;
    t_seg               r_cur, n_cur, r_prev, n_prev, r_next, n_next;
    logic               r_ex_found, n_ex_found;
    logic [IDX_W-1:0]   r_ex_idx, n_ex_idx;
    logic [BASE_W-1:0]  r_ex_base, n_ex_base;
    logic               r_bs_found, n_bs_found;
    logic [IDX_W-1:0]   r_bs_idx, n_bs_idx;
    logic [BASE_W-1:0]  r_bs_base, n_bs_base;
    logic [PAGES_W-1:0] r_bs_pages, n_bs_pages;
    t_out_item          r_result, n_result;
    logic               r_strobe, n_strobe;

    t_cell_ctl ctl;
    t_seg      head;

    logic             accept, head_ok, cfg_wr;
    logic [32:0]      req_sum;
    logic [CMP_W-1:0] req_c, hpages_c, bspages_c, room_c;
    logic [63:0]      hbyte, addr_w;
    logic [CNT_W-1:0] p_w, p_plus1, b_w, a_w;
    logic             nmerge, pmerge, last;
    logic [PAGES_W-1:0] sum1, sum_all;
    logic [BASE_W-1:0]  base_a;

    phwf_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .o_head (head)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_result        = r_result;
    assign o_result_strobe = r_strobe;

    assign req_sum   = {1'b0, i_item.request_bytes} + 33'((1 << PAGE_SHIFT) - 1);
    assign head_ok   = (r_k < r_cnt);
    assign req_c     = CMP_W'(r_req);
    assign hpages_c  = CMP_W'(head.pages);
    assign bspages_c = CMP_W'(r_bs_pages);
    assign room_c    = CMP_W'(r_limit_pg - r_break);
    assign hbyte     = {{(64 - BASE_W){1'b0}}, head.base} << PAGE_SHIFT;
    assign addr_w    = {32'd0, r_addr};

    assign p_w     = {1'b0, r_p};
    assign p_plus1 = p_w + CNT_W'(1);
    assign nmerge  = (p_plus1 < r_cnt) && r_next.is_free;
    assign pmerge  = (r_p != '0) && r_prev.is_free;
    assign sum1    = r_cur.pages + (nmerge ? r_next.pages : PAGES_W'(0));
    assign sum_all = pmerge ? (r_prev.pages + sum1) : sum1;
    assign base_a  = pmerge ? r_prev.base : r_cur.base;
    assign a_w     = pmerge ? (p_w - CNT_W'(1)) : p_w;
    assign b_w     = nmerge ? p_plus1 : p_w;
    assign last    = ((b_w + CNT_W'(1)) == r_cnt);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_break    = r_break;
        n_start_pg = r_start_pg;
        n_limit_pg = r_limit_pg;
        n_small_lo = r_small_lo;
        n_small_hi = r_small_hi;
        n_action   = r_action;
        n_req      = r_req;
        n_addr     = r_addr;
        n_k        = r_k;
        n_last     = r_last;
        n_found    = r_found;
        n_p        = r_p;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_next     = r_next;
        n_ex_found = r_ex_found;
        n_ex_idx   = r_ex_idx;
        n_ex_base  = r_ex_base;
        n_bs_found = r_bs_found;
        n_bs_idx   = r_bs_idx;
        n_bs_base  = r_bs_base;
        n_bs_pages = r_bs_pages;
        n_result   = r_result;
        n_strobe   = 1'b0;
        ctl        = '0;
        ctl.op     = CELL_HOLD;

        case (r_state)
            S_IDLE: begin
                if (cfg_wr) begin
                    if (i_cfg_index == REG_ALLOC_START) begin
                        n_start_pg = i_cfg_data[BASE_W-1:0];
                        if (r_cnt == '0) n_break = {1'b0, i_cfg_data[BASE_W-1:0]};
                    end else if (i_cfg_index == REG_ALLOC_LIMIT) begin
                        n_limit_pg = i_cfg_data[PAGES_W-1:0];
                    end else if (i_cfg_index == REG_SMALL_START) begin
                        n_small_lo = i_cfg_data;
                    end else if (i_cfg_index == REG_SMALL_END) begin
                        n_small_hi = i_cfg_data;
                    end
                end
                if (accept) begin
                    n_action   = i_item.action;
                    n_req      = req_sum[32:PAGE_SHIFT];
                    n_addr     = i_item.release_address;
                    n_k        = '0;
                    n_found    = 1'b0;
                    n_ex_found = 1'b0;
                    n_bs_found = 1'b0;
                    n_next     = '0;
                    n_result   = '0;
                    if (!i_item.action && i_item.request_bytes == '0) begin
                        n_result.status = ST_ZERO_SIZE;
                        n_strobe        = 1'b1;
                    end else if (i_item.action && i_item.release_address >= r_small_lo
                                 && i_item.release_address < r_small_hi) begin
                        n_result.status = ST_SMALL_REGION;
                        n_strobe        = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ctl.op = CELL_ROT;
                n_last = head;
                if (head_ok) begin
                    if (r_action) begin
                        if (!r_found && hbyte == addr_w) begin
                            n_found = 1'b1;
                            n_p     = r_k[IDX_W-1:0];
                            n_cur   = head;
                            n_prev  = r_last;
                        end
                        if (r_found && r_k == p_plus1) n_next = head;
                    end else if (head.is_free && !r_ex_found) begin
                        if (hpages_c == req_c) begin
                            n_ex_found = 1'b1;
                            n_ex_idx   = r_k[IDX_W-1:0];
                            n_ex_base  = head.base;
                        end else if (hpages_c > req_c &&
                                     (!r_bs_found || hpages_c > bspages_c)) begin
                            n_bs_found = 1'b1;
                            n_bs_idx   = r_k[IDX_W-1:0];
                            n_bs_base  = head.base;
                            n_bs_pages = head.pages;
                        end
                    end
                end
                n_k = r_k + CNT_W'(1);
                if (r_k == CNT_W'(MAX_SEGMENTS - 1)) n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_result = '0;
                if (r_action) begin
                    if (!r_found) begin
                        n_result.status = ST_NOT_FOUND;
                    end else if (r_cur.is_free) begin
                        n_result.status = ST_ALREADY_FREE;
                    end else begin
                        n_result.status       = ST_OK;
                        n_result.base_address = to_bytes(32'(r_cur.base));
                        n_result.length_bytes = to_bytes(32'(r_cur.pages));
                        if (last) begin
                            n_cnt   = a_w;
                            n_break = {1'b0, base_a};
                        end else begin
                            ctl.op    = CELL_COLLAPSE;
                            ctl.pos   = a_w[IDX_W-1:0];
                            ctl.span  = {1'b0, nmerge} + {1'b0, pmerge};
                            ctl.ent_a = '{base: base_a, pages: sum_all, is_free: 1'b1};
                            n_cnt     = r_cnt - CNT_W'(ctl.span);
                        end
                    end
                end else if (r_ex_found) begin
                    ctl.op    = CELL_WRITE;
                    ctl.pos   = r_ex_idx;
                    ctl.ent_a = '{base: r_ex_base, pages: PAGES_W'(r_req), is_free: 1'b0};
                    n_result.status       = ST_OK;
                    n_result.base_address = to_bytes(32'(r_ex_base));
                    n_result.length_bytes = to_bytes(32'(r_req));
                end else if (r_bs_found) begin
                    if (r_cnt == CNT_W'(MAX_SEGMENTS)) begin
                        n_result.status = ST_TABLE_FULL;
                    end else begin
                        ctl.op    = CELL_INSERT;
                        ctl.pos   = r_bs_idx;
                        ctl.ent_a = '{base: r_bs_base, pages: PAGES_W'(r_req),
                                      is_free: 1'b0};
                        ctl.ent_b = '{base: r_bs_base + BASE_W'(r_req),
                                      pages: r_bs_pages - PAGES_W'(r_req), is_free: 1'b1};
                        n_cnt     = r_cnt + CNT_W'(1);
                        n_result.status       = ST_OK;
                        n_result.base_address = to_bytes(32'(r_bs_base));
                        n_result.length_bytes = to_bytes(32'(r_req));
                    end
                end else if (r_break >= r_limit_pg || req_c > room_c) begin
                    n_result.status = ST_NO_ROOM;
                end else if (r_cnt == CNT_W'(MAX_SEGMENTS)) begin
                    n_result.status = ST_TABLE_FULL;
                end else begin
                    ctl.op    = CELL_WRITE;
                    ctl.pos   = r_cnt[IDX_W-1:0];
                    ctl.ent_a = '{base: r_break[BASE_W-1:0], pages: PAGES_W'(r_req),
                                  is_free: 1'b0};
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_break   = r_break + PAGES_W'(r_req);
                    n_result.status       = ST_OK;
                    n_result.base_address = to_bytes(32'(r_break[BASE_W-1:0]));
                    n_result.length_bytes = to_bytes(32'(r_req));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_break    <= '0;
            r_start_pg <= '0;
            r_limit_pg <= PAGES_W'(1048576);
            r_small_lo <= '0;
            r_small_hi <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_break    <= n_break;
            r_start_pg <= n_start_pg;
            r_limit_pg <= n_limit_pg;
            r_small_lo <= n_small_lo;
            r_small_hi <= n_small_hi;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_k        <= n_k;
        r_last     <= n_last;
        r_found    <= n_found;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_ex_found <= n_ex_found;
        r_ex_idx   <= n_ex_idx;
        r_ex_base  <= n_ex_base;
        r_bs_found <= n_bs_found;
        r_bs_idx   <= n_bs_idx;
        r_bs_base  <= n_bs_base;
        r_bs_pages <= n_bs_pages;
        r_result   <= n_result;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_apply_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPLY |=> o_result_strobe && r_state == S_IDLE)
        else $error("apply did not give a result");

    a_scan_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> $stable(r_break) && $stable(r_cnt))
        else $error("heap state moved during scan");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> !o_result_strobe)
        else $error("result during scan");
`endif

endmodule
`default_nettype wire
